@@ rtl/ctqr_pkg.sv @@
package ctqr_pkg;

  // Character codes used by the rotator.
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd0;

  // Angles accepted with the last character of a figure.
  localparam logic [8:0] DEG_0   = 9'd0;
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Decoded rotation.
  typedef enum logic [2:0] {
    ANG_0,
    ANG_90,
    ANG_180,
    ANG_270,
    ANG_BAD
  } angle_e;

  // What a fetch turns into once the store has been read.
  typedef enum logic [2:0] {
    KIND_NONE_LEFT,
    KIND_ERROR,
    KIND_NEWLINE,
    KIND_CELL,
    KIND_SPACE
  } kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_in;
    logic       last_char;
    logic [8:0] degrees;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       end_of_output;
    logic       angle_error;
    logic       nothing_left;
  } rsp_t;

endpackage

@@ rtl/ctqr_tile_ram.sv @@
module ctqr_tile_ram #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/char_tile_quarter_rotate_unit.sv @@
// Character tile rotator. Load requests (req_type 0) stream a text figure in,
// one character each; a newline ends a row, a row of MAX_SIDE characters wraps,
// and rows past MAX_SIDE are dropped. The character flagged last_char closes
// the figure, squares it to max(rows, widest row) with space padding, and
// samples degrees. Fetch requests (req_type 1) then return the figure rotated
// clockwise, one character per request, a newline after each row and
// end_of_output on the final newline; a bad angle gives angle_error instead.
// A request is taken every cycle while the result side keeps up; a fetch
// result passes the registered read of the MAX_SIDE*MAX_SIDE tile RAM and then
// the output register. Loads give no result. The RAM needs no clearing after
// reset.
module char_tile_quarter_rotate_unit #(
  parameter int MAX_SIDE = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctqr_pkg::req_t  req_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output ctqr_pkg::rsp_t  rsp_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i
);

  import ctqr_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int RW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SW-1:0] SIDE_MAX   = SW'(MAX_SIDE);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_SIDE);

  // Figure and output position state.
  logic [SW-1:0] row_count_q, row_count_d;
  logic [SW-1:0] col_pos_q, col_pos_d;
  logic [SW-1:0] widest_q, widest_d;
  logic [SW-1:0] side_q, side_d;
  angle_e        angle_q, angle_d;
  logic [SW-1:0] major_q, major_d;
  logic [SW-1:0] minor_q, minor_d;
  logic          pending_q, pending_d;
  logic [SW-1:0] row_len_q [MAX_SIDE];

  // Read stage and output register.
  logic   s1_valid_q;
  kind_e  s1_kind_q, s1_kind_d;
  logic   s1_end_q, s1_end_d;
  logic   out_valid_q;
  rsp_t   out_q, out_d;
  logic   s1_advance;
  logic   accept;

  // Store ports.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata;

  // Row length write.
  logic          len_we;
  logic [RW-1:0] len_idx;
  logic [SW-1:0] len_val;

  assign s1_advance  = !out_valid_q || rsp_ready_i;
  assign req_ready_o = !s1_valid_q || s1_advance;
  assign accept      = req_valid_i && req_ready_o;

  // Request processing: a load updates the figure, a fetch steps the output.
  always_comb begin
    logic [SW-1:0] rc_e, cp_e, wr_e, cp_n, close_len, side_n, s_m1, r, c;
    logic          absorb, do_close, is_nl;
    row_count_d = row_count_q;
    col_pos_d   = col_pos_q;
    widest_d    = widest_q;
    side_d      = side_q;
    angle_d     = angle_q;
    major_d     = major_q;
    minor_d     = minor_q;
    pending_d   = pending_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    len_we      = 1'b0;
    len_idx     = '0;
    len_val     = '0;
    s1_kind_d   = KIND_NONE_LEFT;
    s1_end_d    = 1'b0;
    rc_e = row_count_q;
    cp_e = col_pos_q;
    wr_e = widest_q;
    cp_n = '0;
    close_len = '0;
    side_n = '0;
    absorb = 1'b0;
    do_close = 1'b0;
    is_nl = (req_i.char_in == CH_NL);
    s_m1 = side_q - SW'(1);
    r = '0;
    c = '0;

    if (accept && req_i.req_type == REQ_LOAD) begin
      // A completed figure is dropped by the first load that follows it.
      if (side_q != '0) begin
        rc_e      = '0;
        cp_e      = '0;
        wr_e      = '0;
        side_d    = '0;
        pending_d = 1'b0;
      end
      // A newline right after a row that wrapped is absorbed.
      if (cp_e >= SIDE_MAX) begin
        cp_e   = '0;
        absorb = is_nl;
      end
      cp_n = cp_e;
      if (is_nl && !absorb) begin
        do_close  = 1'b1;
        close_len = cp_e;
        cp_n      = '0;
      end else if (!absorb) begin
        if (rc_e < SIDE_MAX) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(rc_e) * ROW_STRIDE + AW'(cp_e);
        end
        cp_n = cp_e + SW'(1);
        if (cp_n >= SIDE_MAX) begin
          do_close  = 1'b1;
          close_len = cp_n;
        end
      end
      // A partial last row closes with the figure.
      if (req_i.last_char && cp_n != '0 && cp_n < SIDE_MAX) begin
        do_close  = 1'b1;
        close_len = cp_n;
      end
      if (do_close && rc_e < SIDE_MAX) begin
        len_we  = 1'b1;
        len_idx = rc_e[RW-1:0];
        len_val = close_len;
        if (close_len > wr_e) begin
          wr_e = close_len;
        end
        rc_e = rc_e + SW'(1);
      end
      row_count_d = rc_e;
      widest_d    = wr_e;
      col_pos_d   = cp_n;
      // Figure complete: square it and latch the angle.
      if (req_i.last_char) begin
        col_pos_d = '0;
        side_n    = (rc_e > wr_e) ? rc_e : wr_e;
        side_d    = (side_n == '0) ? SW'(1) : side_n;
        if (req_i.degrees == DEG_0) begin
          angle_d = ANG_0;
        end else if (req_i.degrees == DEG_90) begin
          angle_d = ANG_90;
        end else if (req_i.degrees == DEG_180) begin
          angle_d = ANG_180;
        end else if (req_i.degrees == DEG_270) begin
          angle_d = ANG_270;
        end else begin
          angle_d = ANG_BAD;
        end
        major_d   = '0;
        minor_d   = '0;
        pending_d = 1'b1;
      end
    end else if (accept) begin
      if (!pending_q) begin
        s1_kind_d = KIND_NONE_LEFT;
      end else if (angle_q == ANG_BAD) begin
        s1_kind_d = KIND_ERROR;
        s1_end_d  = 1'b1;
        pending_d = 1'b0;
      end else if (minor_q >= side_q) begin
        // Row end: newline, and the end mark after the last row.
        s1_kind_d = KIND_NEWLINE;
        s1_end_d  = (major_q >= s_m1);
        minor_d   = '0;
        major_d   = major_q + SW'(1);
        if (major_q >= s_m1) begin
          pending_d = 1'b0;
        end
      end else begin
        // Map the output position back to a source cell.
        case (angle_q)
          ANG_0: begin
            r = major_q;
            c = minor_q;
          end
          ANG_90: begin
            r = s_m1 - minor_q;
            c = major_q;
          end
          ANG_180: begin
            r = s_m1 - major_q;
            c = s_m1 - minor_q;
          end
          default: begin
            r = minor_q;
            c = s_m1 - major_q;
          end
        endcase
        if (r < row_count_q && c < row_len_q[r[RW-1:0]]) begin
          s1_kind_d = KIND_CELL;
          mem_re    = 1'b1;
          mem_raddr = AW'(r) * ROW_STRIDE + AW'(c);
        end else begin
          s1_kind_d = KIND_SPACE;
        end
        minor_d = minor_q + SW'(1);
      end
    end
  end

  // Result formed from the read stage.
  always_comb begin
    out_d = '0;
    out_d.end_of_output = s1_end_q;
    case (s1_kind_q)
      KIND_NONE_LEFT: out_d.nothing_left = 1'b1;
      KIND_ERROR:     out_d.angle_error = 1'b1;
      KIND_NEWLINE:   out_d.char_out = CH_NL;
      KIND_CELL:      out_d.char_out = mem_rdata;
      KIND_SPACE:     out_d.char_out = CH_SPACE;
      default:        out_d.char_out = CH_ZERO;
    endcase
  end

  // Control and figure state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_pos_q   <= '0;
      widest_q    <= '0;
      side_q      <= '0;
      angle_q     <= ANG_0;
      major_q     <= '0;
      minor_q     <= '0;
      pending_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_count_q <= row_count_d;
      col_pos_q   <= col_pos_d;
      widest_q    <= widest_d;
      side_q      <= side_d;
      angle_q     <= angle_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      pending_q   <= pending_d;
      // The read stage fills on any accepted fetch and empties when it moves on.
      if (accept) begin
        s1_valid_q <= (req_i.req_type == REQ_FETCH);
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers and row lengths.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      row_len_q[len_idx] <= len_val;
    end
    if (accept) begin
      s1_kind_q <= s1_kind_d;
      s1_end_q  <= s1_end_d;
    end
    if (s1_advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  ctqr_tile_ram #(
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.char_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_o       = out_q;
  assign rsp_valid_o = out_valid_q;

endmodule
